/* hw/rtl/dmrpd_pkg.sv */
// shared types, field widths and register codes for the dual motor ramp drive
package dmrpd_pkg;

  localparam int ELAPSED_W  = 16;
  localparam int TARGET_W   = 16;
  localparam int PWM_W      = 8;
  localparam int DEADBAND_W = 15;
  localparam int DUTY_W     = 15;
  localparam int RATE_W     = 10;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_STOP_BAND_A = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP_BAND_B = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_A   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REVERSE_B   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DUTY    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_RATE   = 3'd5;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 15'd819;
  localparam logic [DUTY_W-1:0]     DUTY_RST     = 15'd16384;
  localparam logic [RATE_W-1:0]     RATE_RST     = 10'd16;

  localparam logic [PWM_W-1:0] PWM_OFF = 8'd255;

  typedef struct packed {
    logic [ELAPSED_W-1:0]       elapsed_ms;
    logic signed [TARGET_W-1:0] target_a;
    logic signed [TARGET_W-1:0] target_b;
  } drive_in_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_fwd_a;
    logic [PWM_W-1:0] pwm_rev_a;
    logic [PWM_W-1:0] pwm_fwd_b;
    logic [PWM_W-1:0] pwm_rev_b;
  } drive_out_t;

  // per-stage strobes from the sequencer to both lanes
  typedef struct packed {
    logic load;
    logic ramp;
    logic scale;
    logic pins;
  } lane_ctl_t;

  typedef struct packed {
    logic                  invert;
    logic [DEADBAND_W-1:0] deadband;
    logic [DUTY_W-1:0]     max_duty;
    logic [RATE_W-1:0]     ramp_rate;
  } lane_cfg_t;

endpackage

/* hw/rtl/dmrpd_lane.sv */
// one motor lane: ramp, invert, duty scale, deadband and h-bridge pin mapping
module dmrpd_lane import dmrpd_pkg::*; #(
  parameter int FRAC_BITS     = 14,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctl_t                  ctl,
  input  lane_cfg_t                  cfg,
  input  logic [ELAPSED_W-1:0]       elapsed_ms,
  input  logic signed [TARGET_W-1:0] target,
  output logic [PWM_W-1:0]           fwd,
  output logic [PWM_W-1:0]           rev
);

  localparam int MW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 2;
  localparam int EW = (INTERVAL_BITS < ELAPSED_W) ? INTERVAL_BITS : ELAPSED_W;
  localparam int DW = EW + RATE_W;
  localparam int SW = ((DW > RW) ? DW : RW) + 2;
  localparam int CW = ((DUTY_W > MW) ? DUTY_W : MW) + 1;
  localparam int PW = MW + PWM_W;
  localparam int DFW = PW - FRAC_BITS;
  localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << FRAC_BITS);
  localparam logic [CW-1:0]        ONE_C = CW'(64'd1 << FRAC_BITS);

  logic signed [RW-1:0] ramped;
  logic signed [RW-1:0] tgt;
  logic [DW-1:0]        delta;
  logic                 zero_tgt;
  logic                 neg;
  logic [MW-1:0]        absv;
  logic [MW-1:0]        mag;

  logic signed [SW-1:0] tgt_ext, tgt_clamp;
  logic [DW-1:0]        delta_next;
  logic signed [SW-1:0] ramp_ext, delta_ext, sum, sum_clamp;
  logic signed [RW-1:0] v, vi, vabs;
  logic [CW-1:0]        cap_ext;
  logic [MW-1:0]        cap;
  logic [2*MW-1:0]      sprod;
  logic                 dead;
  logic [MW-1:0]        eff;
  logic [PW-1:0]        pprod;
  logic [DFW-1:0]       diff_w;
  logic [PWM_W-1:0]     diff;
  logic                 pos;

  // load: clamp target, elapsed times rate
  always_comb begin
    tgt_ext = SW'(target);
    if (tgt_ext > ONE_S) begin
      tgt_clamp = ONE_S;
    end else if (tgt_ext < -ONE_S) begin
      tgt_clamp = -ONE_S;
    end else begin
      tgt_clamp = tgt_ext;
    end
    delta_next = DW'(elapsed_ms[EW-1:0]) * DW'(cfg.ramp_rate);
  end

  // ramp: step toward target, saturate, invert
  always_comb begin
    ramp_ext  = SW'(ramped);
    delta_ext = signed'({{(SW-DW){1'b0}}, delta});
    if (tgt > ramped) begin
      sum = ramp_ext + delta_ext;
    end else begin
      sum = ramp_ext - delta_ext;
    end
    if (sum > ONE_S) begin
      sum_clamp = ONE_S;
    end else if (sum < -ONE_S) begin
      sum_clamp = -ONE_S;
    end else begin
      sum_clamp = sum;
    end
    v    = sum_clamp[RW-1:0];
    vi   = cfg.invert ? -v : v;
    vabs = (vi < 0) ? -vi : vi;
  end

  // scale: duty cap limited to one
  always_comb begin
    cap_ext = CW'(cfg.max_duty);
    cap     = (cap_ext > ONE_C) ? ONE_C[MW-1:0] : cap_ext[MW-1:0];
    sprod   = (2*MW)'(absv) * (2*MW)'(cap);
  end

  // pins: deadband, times 255, bridge mapping
  always_comb begin
    dead   = zero_tgt && (CW'(mag) < CW'(cfg.deadband));
    eff    = dead ? '0 : mag;
    pprod  = {eff, {PWM_W{1'b0}}} - PW'(eff);
    diff_w = pprod[PW-1:FRAC_BITS];
    diff   = (diff_w > DFW'(PWM_OFF)) ? PWM_OFF : diff_w[PWM_W-1:0];
    pos    = !neg && (eff != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramped <= '0;
    end else if (ctl.ramp) begin
      ramped <= v;
    end else if (ctl.pins && dead) begin
      ramped <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tgt      <= tgt_clamp[RW-1:0];
      zero_tgt <= (tgt_clamp == '0);
      delta    <= delta_next;
    end
    if (ctl.ramp) begin
      neg  <= (vi < 0);
      absv <= vabs[MW-1:0];
    end
    if (ctl.scale) begin
      mag <= sprod[FRAC_BITS +: MW];
    end
    if (ctl.pins) begin
      fwd <= pos ? PWM_OFF - diff : PWM_OFF;
      rev <= pos ? PWM_OFF : PWM_OFF - diff;
    end
  end

endmodule

/* hw/rtl/dual_motor_ramp_pwm_drive.sv */
// top level of the dual motor ramp drive: register file, sequencer, lanes and merge
//
// usage:
//   - in channel (in_valid/in_ready/in_data) carries one control tick: elapsed
//     milliseconds and a q1.14 target velocity per motor
//   - out channel (out_valid/out_ready/out_data) carries the four h-bridge pwm
//     values, one result per tick except the first tick after reset
//   - apb port writes and reads six registers at byte offsets 0..20; write only
//     while no request is in flight
//   - a tick is taken when the sequencer is idle; both motor lanes then run in
//     parallel through ramp, scale and pin stages, and the result moves into
//     the merge register once that register is free or draining
//   - a new request is taken only after the last one has passed the four lane
//     stages and the hand-off into the output register
//   - the output register frees the lanes, so a new request is taken while a
//     result still waits; a third request waits until out_ready drains it
//   - reset clears both ramped velocities and the armed flag, restores register
//     defaults; the first tick after reset only arms the block
module dual_motor_ramp_pwm_drive import dmrpd_pkg::*; #(
  parameter int FRAC_BITS     = 14,
  parameter int INTERVAL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  drive_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output drive_out_t        out_data
);

  // sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RAMP  = 3'd1;
  localparam logic [2:0] PH_SCALE = 3'd2;
  localparam logic [2:0] PH_PINS  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  // configuration registers
  logic [DEADBAND_W-1:0] stop_band_a, stop_band_b;
  logic                  reverse_a, reverse_b;
  logic [DUTY_W-1:0]     max_duty;
  logic [RATE_W-1:0]     ramp_rate;

  logic [2:0]           phase, phase_next;
  logic                 armed;
  logic                 accept;
  logic                 push;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  lane_ctl_t            ctl;
  lane_cfg_t            cfg_a, cfg_b;
  logic [PWM_W-1:0]     fwd_a, rev_a, fwd_b, rev_b;

  // apb access, always ready, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_band_a <= DEADBAND_RST;
      stop_band_b <= DEADBAND_RST;
      reverse_a   <= 1'b0;
      reverse_b   <= 1'b0;
      max_duty    <= DUTY_RST;
      ramp_rate   <= RATE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STOP_BAND_A: stop_band_a <= pwdata[DEADBAND_W-1:0];
        REG_STOP_BAND_B: stop_band_b <= pwdata[DEADBAND_W-1:0];
        REG_REVERSE_A:   reverse_a   <= pwdata[0];
        REG_REVERSE_B:   reverse_b   <= pwdata[0];
        REG_MAX_DUTY:    max_duty    <= pwdata[DUTY_W-1:0];
        REG_RAMP_RATE:   ramp_rate   <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback, zero extended
  always_comb begin
    case (reg_idx)
      REG_STOP_BAND_A: prdata = APB_DW'(stop_band_a);
      REG_STOP_BAND_B: prdata = APB_DW'(stop_band_b);
      REG_REVERSE_A:   prdata = APB_DW'(reverse_a);
      REG_REVERSE_B:   prdata = APB_DW'(reverse_b);
      REG_MAX_DUTY:    prdata = APB_DW'(max_duty);
      REG_RAMP_RATE:   prdata = APB_DW'(ramp_rate);
      default:         prdata = '0;
    endcase
  end

  // request side: only the idle phase takes a tick
  assign in_ready = (phase == PH_IDLE);
  assign accept   = in_valid && in_ready;
  // result moves to the output register when that register is free or draining
  assign push     = (phase == PH_DONE) && (!out_valid || out_ready);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:  if (accept && armed) phase_next = PH_RAMP;
      PH_RAMP:  phase_next = PH_SCALE;
      PH_SCALE: phase_next = PH_PINS;
      PH_PINS:  phase_next = PH_DONE;
      PH_DONE:  if (push) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      armed <= 1'b0;
    end else begin
      phase <= phase_next;
      // the arming tick is swallowed without starting the lanes
      if (accept) begin
        armed <= 1'b1;
      end
    end
  end

  // shared stage strobes for both lanes
  assign ctl.load  = accept && armed;
  assign ctl.ramp  = (phase == PH_RAMP);
  assign ctl.scale = (phase == PH_SCALE);
  assign ctl.pins  = (phase == PH_PINS);

  assign cfg_a = '{invert: reverse_a, deadband: stop_band_a, max_duty: max_duty,
                   ramp_rate: ramp_rate};
  assign cfg_b = '{invert: reverse_b, deadband: stop_band_b, max_duty: max_duty,
                   ramp_rate: ramp_rate};

  // motor a lane
  dmrpd_lane #(
    .FRAC_BITS    (FRAC_BITS),
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg_a),
    .elapsed_ms(in_data.elapsed_ms),
    .target    (in_data.target_a),
    .fwd       (fwd_a),
    .rev       (rev_a)
  );

  // motor b lane
  dmrpd_lane #(
    .FRAC_BITS    (FRAC_BITS),
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg_b),
    .elapsed_ms(in_data.elapsed_ms),
    .target    (in_data.target_b),
    .fwd       (fwd_b),
    .rev       (rev_b)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.pwm_fwd_a <= fwd_a;
      out_data.pwm_rev_a <= rev_a;
      out_data.pwm_fwd_b <= fwd_b;
      out_data.pwm_rev_b <= rev_b;
    end
  end

  // the arming tick leaves the sequencer idle
  a_arm_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !armed) |=> (phase == PH_IDLE) && armed)
    else $error("arming request started the lanes");

  // an armed request starts the ramp stage next cycle
  a_armed_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && armed) |=> (phase == PH_RAMP))
    else $error("armed request did not start the lanes");

  // a hand-off always shows up as a valid result
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid && (phase == PH_IDLE))
    else $error("result hand-off lost");

  // at most one lane stage strobe per cycle
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.ramp, ctl.scale, ctl.pins}))
    else $error("overlapping lane stage strobes");

  // each bridge keeps at least one pin off
  a_bridge_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.pwm_fwd_a == PWM_OFF) || (out_data.pwm_rev_a == PWM_OFF))
                  && ((out_data.pwm_fwd_b == PWM_OFF) || (out_data.pwm_rev_b == PWM_OFF)))
    else $error("both bridge pins driven");

endmodule

/* test/dmrpd_tb_pkg.sv */
// pwm prediction and result checking for the dual motor ramp drive testbench
`timescale 1ns / 1ps
package dmrpd_tb_pkg;
  import dmrpd_pkg::*;

  localparam int    Q_FRAC = 14;
  localparam longint UNIT_Q = longint'(1) << Q_FRAC;

  typedef struct packed {
    logic signed [TARGET_W-1:0] ramped;
    logic [PWM_W-1:0]           fwd;
    logic [PWM_W-1:0]           rev;
  } lane_result_t;

  function automatic longint clip_unit(longint v);
    if (v > UNIT_Q) return UNIT_Q;
    if (v < -UNIT_Q) return -UNIT_Q;
    return v;
  endfunction

  class drive_scoreboard;
    logic [DEADBAND_W-1:0]      stop_band_a, stop_band_b;
    logic                       reverse_a, reverse_b;
    logic [DUTY_W-1:0]          max_duty;
    logic [RATE_W-1:0]          ramp_rate;
    logic signed [TARGET_W-1:0] ramped_a, ramped_b;
    bit                         armed;
    drive_out_t                 pwm_due[$];
    int                         errors;

    function new();
      stop_band_a = DEADBAND_RST;
      stop_band_b = DEADBAND_RST;
      reverse_a   = 1'b0;
      reverse_b   = 1'b0;
      max_duty    = DUTY_RST;
      ramp_rate   = RATE_RST;
      ramped_a    = '0;
      ramped_b    = '0;
      armed       = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_STOP_BAND_A: stop_band_a = value[DEADBAND_W-1:0];
        REG_STOP_BAND_B: stop_band_b = value[DEADBAND_W-1:0];
        REG_REVERSE_A:   reverse_a = value[0];
        REG_REVERSE_B:   reverse_b = value[0];
        REG_MAX_DUTY:    max_duty = value[DUTY_W-1:0];
        REG_RAMP_RATE:   ramp_rate = value[RATE_W-1:0];
        default: ;
      endcase
    endfunction

    // ramp one motor, then invert, scale, apply the stop deadband and map to pins
    function lane_result_t lane_pwm(logic signed [TARGET_W-1:0] ramped,
                                    logic signed [TARGET_W-1:0] target,
                                    logic [ELAPSED_W-1:0] ms, logic invert,
                                    logic [DEADBAND_W-1:0] deadband);
      lane_result_t r;
      longint goal, speed, cap, mag, level;
      goal  = clip_unit(longint'(target));
      speed = longint'(ramped);
      // a target equal to the ramped value still steps down
      if (goal > speed) begin
        speed = speed + longint'(ms) * longint'(ramp_rate);
      end else begin
        speed = speed - longint'(ms) * longint'(ramp_rate);
      end
      speed    = clip_unit(speed);
      r.ramped = TARGET_W'(speed);
      if (invert) begin
        speed = -speed;
      end
      cap = (longint'(max_duty) > UNIT_Q) ? UNIT_Q : longint'(max_duty);
      mag = ((speed < 0 ? -speed : speed) * cap) >>> Q_FRAC;
      if (goal == 0 && mag < longint'(deadband)) begin
        mag      = 0;
        r.ramped = '0;
      end
      level = (mag * 255) >>> Q_FRAC;
      if (level > 255) begin
        level = 255;
      end
      if (speed > 0 && mag > 0) begin
        r.fwd = PWM_OFF - PWM_W'(level);
        r.rev = PWM_OFF;
      end else begin
        r.fwd = PWM_OFF;
        r.rev = PWM_OFF - PWM_W'(level);
      end
      return r;
    endfunction

    function void note_request(drive_in_t req);
      lane_result_t a, b;
      drive_out_t   due;
      if (!armed) begin
        armed = 1'b1;
        return;
      end
      a = lane_pwm(ramped_a, req.target_a, req.elapsed_ms, reverse_a, stop_band_a);
      b = lane_pwm(ramped_b, req.target_b, req.elapsed_ms, reverse_b, stop_band_b);
      ramped_a      = a.ramped;
      ramped_b      = b.ramped;
      due.pwm_fwd_a = a.fwd;
      due.pwm_rev_a = a.rev;
      due.pwm_fwd_b = b.fwd;
      due.pwm_rev_b = b.rev;
      pwm_due.push_back(due);
    endfunction

    function void check_result(drive_out_t got);
      drive_out_t want;
      if (pwm_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: pwm result %h with no request pending", got);
        end
        return;
      end
      want = pwm_due.pop_front();
      if (got.pwm_fwd_a !== want.pwm_fwd_a || got.pwm_rev_a !== want.pwm_rev_a ||
          got.pwm_fwd_b !== want.pwm_fwd_b || got.pwm_rev_b !== want.pwm_rev_b) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: fwd_a %0d/%0d rev_a %0d/%0d fwd_b %0d/%0d rev_b %0d/%0d",
                   want.pwm_fwd_a, got.pwm_fwd_a, want.pwm_rev_a, got.pwm_rev_a,
                   want.pwm_fwd_b, got.pwm_fwd_b, want.pwm_rev_b, got.pwm_rev_b);
        end
      end
    endfunction

    function int pending();
      return pwm_due.size();
    endfunction
  endclass

endpackage

/* test/tb_dual_motor_ramp_pwm_drive.sv */
// testbench top for the dual motor ramp drive: directed and random ticks, apb settings
`timescale 1ns / 1ps
module tb_dual_motor_ramp_pwm_drive;
  import dmrpd_pkg::*;
  import dmrpd_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 10;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  drive_in_t         in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  drive_out_t        out_data;

  drive_scoreboard sb;

  // quiet: no idling on either side; hold_asked/hold_taken hand a hold-off to the receiver
  bit quiet = 1'b0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  dual_motor_ramp_pwm_drive u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off counted here when one is asked for
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst && (quiet || $urandom_range(0, 99) >= 7);
    end
  end

  // every result taken by the receiver is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // offer one tick request and hold it until the block takes it
  task automatic send_tick(input logic [ELAPSED_W-1:0] ms,
                           input logic signed [TARGET_W-1:0] tgt_a,
                           input logic signed [TARGET_W-1:0] tgt_b);
    drive_in_t req;
    req.elapsed_ms = ms;
    req.target_a = tgt_a;
    req.target_b = tgt_b;
    // sender gap, only before a new request so valid is never dropped mid-request
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // apb write: setup, access, then idle so writes never overlap
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // drop valid, wait for every predicted result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // targets: mostly in range, a share of exact zeros for the deadband, some raw 16-bit values
  function automatic logic signed [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return TARGET_W'($urandom());
      default: return TARGET_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // elapsed time: mostly short so the ramp moves in steps, sometimes zero or any value
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0: return ELAPSED_W'($urandom());
      1: return '0;
      default: return ELAPSED_W'($urandom_range(1, 40));
    endcase
  endfunction

  // 15-bit q1.14 register value, extremes included
  function automatic logic [APB_DW-1:0] pick_fraction();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32767;
      2: return 16384;
      3: return $urandom_range(0, 2000);
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  task automatic random_settings();
    apb_write(REG_STOP_BAND_A, pick_fraction());
    apb_write(REG_STOP_BAND_B, pick_fraction());
    apb_write(REG_REVERSE_A, $urandom_range(0, 1));
    apb_write(REG_REVERSE_B, $urandom_range(0, 1));
    apb_write(REG_MAX_DUTY, pick_fraction());
    case ($urandom_range(0, 3))
      0: apb_write(REG_RAMP_RATE, 0);
      1: apb_write(REG_RAMP_RATE, 1023);
      default: apb_write(REG_RAMP_RATE, $urandom_range(1, 100));
    endcase
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults; first tick only arms the block
    send_tick(16'd12345, 16'sd16384, -16'sd16384);
    send_tick(16'd0, 16'sd0, 16'sd0);
    send_tick(16'd1000, 16'sd16384, -16'sd16384);
    // longest elapsed time and out-of-range targets, both ramps saturate
    send_tick(16'hFFFF, 16'sh7FFF, 16'sh8000);
    // target equal to ramped value: a steps down, b stays clamped at minus one
    send_tick(16'd1, 16'sd16384, -16'sd16384);
    send_tick(16'd40, 16'sd0, 16'sd0);
    // both ramps land inside the deadband with a zero target
    send_tick(16'd1000, 16'sd0, 16'sd0);
    send_tick(16'd3, 16'sd100, -16'sd100);
    send_tick(16'd0, -16'sd1, 16'sd1);
    send_tick(16'd2, 16'sd16383, -16'sd16383);
    settle();

    // no deadband on a, huge on b, a inverted, duty above one, fastest ramp
    apb_write(REG_STOP_BAND_A, 0);
    apb_write(REG_STOP_BAND_B, 32767);
    apb_write(REG_REVERSE_A, 1);
    apb_write(REG_REVERSE_B, 0);
    apb_write(REG_MAX_DUTY, 32767);
    apb_write(REG_RAMP_RATE, 1023);
    send_tick(16'd16, 16'sd16384, 16'sd16384);
    send_tick(16'd1, 16'sd0, 16'sd0);
    send_tick(16'hFFFF, 16'sh8000, 16'sh7FFF);
    send_tick(16'd0, 16'sd0, 16'sd0);
    send_tick(16'd5, -16'sd5000, 16'sd5000);
    settle();

    // zero duty and a frozen ramp, b inverted
    apb_write(REG_STOP_BAND_A, 32767);
    apb_write(REG_STOP_BAND_B, 0);
    apb_write(REG_REVERSE_A, 0);
    apb_write(REG_REVERSE_B, 1);
    apb_write(REG_MAX_DUTY, 0);
    apb_write(REG_RAMP_RATE, 0);
    send_tick(16'hFFFF, 16'sd16384, -16'sd16384);
    send_tick(16'd100, 16'sd0, 16'sd0);
    send_tick(16'd7, 16'sd1234, -16'sd1234);
    settle();

    // random phases, each with fresh settings
    for (int phase = 0; phase < 6; phase++) begin
      random_settings();
      quiet = (phase == 2);
      if (phase == 3) begin
        // receiver stops for a long stretch while requests keep coming
        hold_asked <= hold_asked + 1;
      end
      repeat (115) send_tick(pick_elapsed(), pick_target(), pick_target());
      settle();
    end

    quiet = 1'b0;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
